[rtl/fixed_partition_fit_allocator_unit_defines.svh]
// assertion macros for the fixed partition fit allocator
// no dependencies; included by the modules that carry assertions
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FPFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fpfa_pkg.sv]
// shared constants, codes and types of the fixed partition fit allocator
// no dependencies
package fpfa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int REQ_W      = 16;
    localparam int LIDX_W     = 4;
    localparam int CHOSEN_W   = 4;
    localparam int BCNT_W     = 5;
    localparam int CMP_W      = ((SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W) + 1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        M_FIRST = 2'd0,
        M_WORST = 2'd1,
        M_BEST  = 2'd2,
        M_BAD   = 2'd3
    } t_method;

    typedef enum logic [1:0] {
        ST_ALLOC     = 2'd0,
        ST_NOFIT     = 2'd1,
        ST_BADMETHOD = 2'd2,
        ST_LOADED    = 2'd3
    } t_status;

    typedef struct packed {
        logic    clear;
        logic    eval;
        t_method method;
    } t_pick_ctl;

    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
    } t_pick_res;

endpackage

[rtl/fpfa_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module fpfa_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 17,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fpfa_pick.sv]
// candidate selection for first, worst and best fit over a streamed scan
// depends on fpfa_pkg
module fpfa_pick (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fpfa_pkg::t_pick_ctl            i_ctl,
    input  logic [fpfa_pkg::IDX_W-1:0]     i_idx,
    input  logic [fpfa_pkg::SIZE_BITS-1:0] i_size,
    input  logic                           i_taken,
    input  logic [fpfa_pkg::REQ_W-1:0]     i_request,
    output fpfa_pkg::t_pick_res            o_res
);

    logic                           r_found;
    logic [fpfa_pkg::IDX_W-1:0]     r_idx;
    logic [fpfa_pkg::SIZE_BITS-1:0] r_size;
    logic                           fits;
    logic                           better;
    logic                           take;

    // full-width compare so a request wider than a stored size never fits by wrap
    assign fits = !i_taken &&
                  (fpfa_pkg::CMP_W'(i_size) >= fpfa_pkg::CMP_W'(i_request));

    always_comb begin
        case (i_ctl.method)
            fpfa_pkg::M_WORST: better = i_size > r_size;
            fpfa_pkg::M_BEST:  better = i_size < r_size;
            default:           better = 1'b0;
        endcase
    end

    // strict compare keeps ties at the lowest index
    assign take = i_ctl.eval && fits && (!r_found || better);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.clear) begin
            r_idx  <= i_idx;
            r_size <= i_size;
        end
    end

    assign o_res.found = r_found;
    assign o_res.idx   = r_idx;
    assign o_res.size  = r_size;

endmodule

[rtl/fixed_partition_fit_allocator_unit.sv]
// fixed partition fit allocator top level; depends on fpfa_pkg, fpfa_ram, fpfa_pick
// load and bad-method transfers: result strobes in the next cycle, next start taken then
// allocation: the scan reads min(block_count, NUM_BLOCKS) partitions, one per cycle, then
// settles the last read in the pick and commits; the result strobes after the commit
// the receiver cannot stall; busy drops in the cycle the result strobes
// sync active-low reset clears block_count, all loaded flags and the control state
module fixed_partition_fit_allocator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: block_count
    input  logic                            i_cfg_we,
    input  logic [fpfa_pkg::BCNT_W-1:0]     i_cfg_wdata,
    // command
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic [fpfa_pkg::LIDX_W-1:0]     i_load_index,
    input  logic [fpfa_pkg::SIZE_BITS-1:0]  i_load_size,
    input  logic [fpfa_pkg::REQ_W-1:0]      i_request_size,
    input  logic [1:0]                      i_fit_method,
    // result
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [fpfa_pkg::CHOSEN_W-1:0]   o_chosen_index
);

    `include "fixed_partition_fit_allocator_unit_defines.svh"

    localparam int IDX_W  = fpfa_pkg::IDX_W;
    localparam int CNT_W  = fpfa_pkg::CNT_W;
    localparam int SIZE_W = fpfa_pkg::SIZE_BITS;
    localparam int WORD_W = SIZE_W + 1;

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state                         r_state, n_state;
    logic [fpfa_pkg::BCNT_W-1:0]    r_block_count;
    logic [fpfa_pkg::NUM_BLOCKS-1:0] r_valid;      // entry loaded since reset
    logic [CNT_W-1:0]               r_limit;       // partitions scanned this request
    logic [CNT_W-1:0]               r_addr;        // next read address
    logic                           r_rd_vld;      // ram data in flight this cycle
    logic                           r_rd_ok;       // that entry was ever loaded
    logic [IDX_W-1:0]               r_rd_idx;
    logic [fpfa_pkg::REQ_W-1:0]     r_req;
    fpfa_pkg::t_method              r_method;
    logic                           r_done;
    fpfa_pkg::t_status              r_status;
    logic [fpfa_pkg::CHOSEN_W-1:0]  r_chosen;

    logic                           accept;
    logic                           acc_load;
    logic                           acc_alloc;
    logic                           acc_bad;
    logic                           load_in_table;
    logic                           issue;
    logic                           commit_hit;
    logic                           ram_we;
    logic [IDX_W-1:0]               ram_waddr;
    logic [WORD_W-1:0]              ram_wdata;
    logic [WORD_W-1:0]              ram_rdata;
    logic [CNT_W-1:0]               limit_in;
    fpfa_pkg::t_pick_ctl            pick_ctl;
    fpfa_pkg::t_pick_res            pick_res;

    // ---------------------------------------------------------------
    // command decode
    // ---------------------------------------------------------------
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign acc_load  = accept && (i_func == fpfa_pkg::FUNC_LOAD);
    assign acc_alloc = accept && (i_func == fpfa_pkg::FUNC_ALLOC) &&
                       (fpfa_pkg::t_method'(i_fit_method) != fpfa_pkg::M_BAD);
    assign acc_bad   = accept && (i_func == fpfa_pkg::FUNC_ALLOC) &&
                       (fpfa_pkg::t_method'(i_fit_method) == fpfa_pkg::M_BAD);

    assign load_in_table = (int'(i_load_index) < fpfa_pkg::NUM_BLOCKS);

    // a count above the table size scans the whole table
    assign limit_in = (int'(r_block_count) > fpfa_pkg::NUM_BLOCKS) ?
                      CNT_W'(fpfa_pkg::NUM_BLOCKS) : CNT_W'(r_block_count);

    // ---------------------------------------------------------------
    // scan control: one ram read per cycle, its data evaluated in the following cycle, never later
    // ---------------------------------------------------------------
    assign issue      = (r_state == S_SCAN) && (r_addr < r_limit);
    assign commit_hit = (r_state == S_COMMIT) && pick_res.found;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_alloc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // last read is evaluated at this edge, so commit reads a settled pick
                if (!issue) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_block_count <= '0;
            r_valid       <= '0;
            r_rd_vld      <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            r_done   <= acc_load || acc_bad || (r_state == S_COMMIT);
            if (i_cfg_we) begin
                r_block_count <= i_cfg_wdata;
            end
            if (acc_load && load_in_table) begin
                r_valid[IDX_W'(i_load_index)] <= 1'b1;
            end
        end
    end

    // payload and scan datapath registers
    always_ff @(posedge i_clk) begin
        if (acc_alloc) begin
            r_limit  <= limit_in;
            r_addr   <= '0;
            r_req    <= i_request_size;
            r_method <= fpfa_pkg::t_method'(i_fit_method);
        end else if (issue) begin
            r_addr <= r_addr + CNT_W'(1);
        end
        if (issue) begin
            r_rd_idx <= r_addr[IDX_W-1:0];
            r_rd_ok  <= r_valid[r_addr[IDX_W-1:0]];
        end
        if (acc_load) begin
            r_status <= fpfa_pkg::ST_LOADED;
            r_chosen <= '0;
        end else if (acc_bad) begin
            r_status <= fpfa_pkg::ST_BADMETHOD;
            r_chosen <= '0;
        end else if (r_state == S_COMMIT) begin
            r_status <= pick_res.found ? fpfa_pkg::ST_ALLOC : fpfa_pkg::ST_NOFIT;
            r_chosen <= pick_res.found ? fpfa_pkg::CHOSEN_W'(pick_res.idx) : '0;
        end
    end

    // ---------------------------------------------------------------
    // partition ram: {allocated mark, size}; a load clears the mark,
    // a commit that found a fit writes the mark back with the size it read
    // ---------------------------------------------------------------
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = IDX_W'(i_load_index);
        ram_wdata = {1'b0, SIZE_W'(i_load_size)};
        if (acc_load && load_in_table) begin
            ram_we = 1'b1;
        end else if (commit_hit) begin
            ram_we    = 1'b1;
            ram_waddr = pick_res.idx;
            ram_wdata = {1'b1, pick_res.size};
        end
    end

    fpfa_ram #(
        .DEPTH (fpfa_pkg::NUM_BLOCKS),
        .WIDTH (WORD_W),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (issue),
        .i_raddr(r_addr[IDX_W-1:0]),
        .o_rdata(ram_rdata)
    );

    // ---------------------------------------------------------------
    // fit selection; an entry never loaded reads as free with size zero
    // ---------------------------------------------------------------
    assign pick_ctl.clear  = acc_alloc;
    assign pick_ctl.eval   = r_rd_vld;
    assign pick_ctl.method = r_method;

    fpfa_pick u_pick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (pick_ctl),
        .i_idx    (r_rd_idx),
        .i_size   (r_rd_ok ? ram_rdata[SIZE_W-1:0] : '0),
        .i_taken  (r_rd_ok && ram_rdata[SIZE_W]),
        .i_request(r_req),
        .o_res    (pick_res)
    );

    // result ports
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_chosen_index = r_chosen;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `FPFA_ASSERT_NOW(a_no_done_in_scan, i_clk, i_rst_n,
        r_state == S_SCAN, !r_done, "result strobed during a scan")
    `FPFA_ASSERT_NOW(a_no_read_at_commit, i_clk, i_rst_n,
        r_state == S_COMMIT, !r_rd_vld && !issue, "ram read still in flight at commit")
    `FPFA_ASSERT_NEXT(a_commit_gives_done, i_clk, i_rst_n,
        r_state == S_COMMIT, r_done && !busy, "commit not followed by a result")
    `FPFA_ASSERT_NOW(a_alloc_in_range, i_clk, i_rst_n,
        r_done && (r_status == fpfa_pkg::ST_ALLOC), int'(r_chosen) < int'(r_limit),
        "allocated partition outside the scanned range")
    `FPFA_ASSERT_NOW(a_index_zero, i_clk, i_rst_n,
        r_done && (r_status != fpfa_pkg::ST_ALLOC), r_chosen == '0,
        "index not zero without an allocation")

endmodule
